/* sv/rgbhsl_pkg.sv */
package rgbhsl_pkg;

    // Input pixel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Converted result
    typedef struct packed {
        logic [8:0]  hue;
        logic [14:0] saturation_q8;
        logic [14:0] lightness_q8;
    } hsl_t;

    // Channel that holds the maximum
    localparam logic [1:0] MAX_RED   = 2'd0;
    localparam logic [1:0] MAX_GREEN = 2'd1;
    localparam logic [1:0] MAX_BLUE  = 2'd2;

    // Hue dividend offsets: sector offset plus one full turn
    localparam logic [9:0] TURN_RED   = 10'd360;
    localparam logic [9:0] TURN_GREEN = 10'd480;
    localparam logic [9:0] TURN_BLUE  = 10'd600;
    localparam logic [8:0] HUE_TURN   = 9'd360;

    // 100 percent in Q8
    localparam logic [14:0] PCT_Q8 = 15'd25600;

    // Lightness = 50*s + floor(10*s/51); 10/51 done as s*205610 >> 20
    localparam logic [5:0]  LIGHT_WHOLE = 6'd50;
    localparam logic [17:0] LIGHT_RECIP = 18'd205610;

    // Quotient bits of both dividers, one per stage
    localparam int QUOT_W = 15;

    // Cycles from an accepted request to its done strobe
    localparam int LATENCY = QUOT_W + 3;

endpackage

/* sv/rgb_to_hsl_converter.sv */
// RGB to HSL converter, fully pipelined.
//
// Requests: drive pixel and raise start; a request is taken at every rising
// edge where start is high and busy is low. Busy stays low, so a new pixel
// may be issued in every cycle and pixels carry no state between them.
// Results: hsl holds hue in degrees (0..359) and saturation and lightness
// as percent in Q8 (0..25600). done is high for exactly one cycle per
// request, in request order; the receiver must take it in that cycle.
// Pipeline: one stage finds max and min, one stage forms the dividends,
// fifteen stages of two restoring dividers produce one quotient bit each,
// and one stage wraps the hue and registers the result.
// Throughput is one pixel a cycle.
// Gray pixels (all channels equal) give hue 0 and saturation 0.
// Reset clears every valid bit, so all requests in flight are dropped and
// done stays low until a new request has gone through the pipeline.
module rgb_to_hsl_converter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  rgbhsl_pkg::rgb_t    pixel,
    output logic                done,
    output rgbhsl_pkg::hsl_t    hsl
);

    import rgbhsl_pkg::*;

    // Stage 1: max/min and differences
    logic              s1_vld_reg;
    logic [7:0]        s1_d_reg;
    logic [8:0]        s1_s_reg;
    logic signed [8:0] s1_num_reg;
    logic [1:0]        s1_imax_reg;

    logic [1:0]        imax_next;
    logic [7:0]        hi_next;
    logic [7:0]        lo_next;
    logic signed [8:0] num_next;

    // Stage 2: dividends and lightness terms
    logic              s2_vld_reg;
    logic              s2_gray_reg;
    logic [22:0]       s2_sat_dvd_reg;
    logic [7:0]        s2_den_reg;
    logic [17:0]       s2_hue_dvd_reg;
    logic [7:0]        s2_d_reg;
    logic [14:0]       s2_light_base_reg;
    logic [6:0]        s2_light_frac_reg;

    logic [9:0]         turn;
    logic [17:0]        turn_prod;
    logic signed [18:0] num_ext;
    logic signed [18:0] sector;
    logic signed [18:0] hue_total;
    logic [26:0]        light_prod;
    logic [7:0]         den_next;

    // Divider outputs
    logic              sat_vld;
    logic              hue_vld;
    logic [QUOT_W-1:0] sat_quot;
    logic [QUOT_W-1:0] hue_quot;
    logic [14:0]       light_out;
    logic              gray_out;
    logic [QUOT_W-1:0] hue_wrap;

    // Output register
    logic done_reg;
    hsl_t hsl_reg;
    hsl_t hsl_next;

    assign busy = 1'b0;

    // Find the max channel (first wins ties) and its hue numerator
    always_comb
    begin
        if (pixel.red >= pixel.green && pixel.red >= pixel.blue)
        begin
            imax_next = MAX_RED;
            hi_next   = pixel.red;
        end
        else if (pixel.green >= pixel.blue)
        begin
            imax_next = MAX_GREEN;
            hi_next   = pixel.green;
        end
        else
        begin
            imax_next = MAX_BLUE;
            hi_next   = pixel.blue;
        end

        if (pixel.red <= pixel.green && pixel.red <= pixel.blue)
        begin
            lo_next = pixel.red;
        end
        else if (pixel.green <= pixel.blue)
        begin
            lo_next = pixel.green;
        end
        else
        begin
            lo_next = pixel.blue;
        end

        case (imax_next)
            MAX_RED:
            begin
                num_next = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
            end
            MAX_GREEN:
            begin
                num_next = $signed({1'b0, pixel.blue}) - $signed({1'b0, pixel.red});
            end
            default:
            begin
                num_next = $signed({1'b0, pixel.red}) - $signed({1'b0, pixel.green});
            end
        endcase
    end

    // Form dividends: saturation d*25600/den, hue (60*num + turn*d)/d
    always_comb
    begin
        case (s1_imax_reg)
            MAX_RED:   turn = TURN_RED;
            MAX_GREEN: turn = TURN_GREEN;
            default:   turn = TURN_BLUE;
        endcase
        turn_prod  = 18'(turn * s1_d_reg);
        num_ext    = 19'(s1_num_reg);
        sector     = num_ext * 19'sd60;
        hue_total  = $signed({1'b0, turn_prod}) + sector;
        light_prod = 27'(s1_s_reg * LIGHT_RECIP);
        den_next   = s1_s_reg[8] ? 8'(9'd510 - s1_s_reg) : s1_s_reg[7:0];
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start && !busy;
            s2_vld_reg <= s1_vld_reg;
            done_reg   <= sat_vld && hue_vld;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        s1_d_reg          <= hi_next - lo_next;
        s1_s_reg          <= {1'b0, hi_next} + {1'b0, lo_next};
        s1_num_reg        <= num_next;
        s1_imax_reg       <= imax_next;

        s2_gray_reg       <= (s1_d_reg == 8'd0);
        s2_d_reg          <= s1_d_reg;
        s2_den_reg        <= den_next;
        s2_sat_dvd_reg    <= 23'(s1_d_reg * PCT_Q8);
        s2_hue_dvd_reg    <= hue_total[17:0];
        s2_light_base_reg <= 15'(s1_s_reg * LIGHT_WHOLE);
        s2_light_frac_reg <= light_prod[26:20];

        hsl_reg           <= hsl_next;
    end

    // Saturation divider, carries lightness alongside
    rgbhsl_div #(
        .DVS_W  (8),
        .QUOT_W (QUOT_W),
        .SIDE_W (15)
    ) u_sat_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_vld_reg),
        .dividend  (s2_sat_dvd_reg),
        .divisor   (s2_den_reg),
        .in_side   (s2_light_base_reg + {8'd0, s2_light_frac_reg}),
        .out_valid (sat_vld),
        .quotient  (sat_quot),
        .out_side  (light_out)
    );

    // Hue divider, carries the gray flag alongside
    rgbhsl_div #(
        .DVS_W  (8),
        .QUOT_W (QUOT_W),
        .SIDE_W (1)
    ) u_hue_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_vld_reg),
        .dividend  ({5'd0, s2_hue_dvd_reg}),
        .divisor   (s2_d_reg),
        .in_side   (s2_gray_reg),
        .out_valid (hue_vld),
        .quotient  (hue_quot),
        .out_side  (gray_out)
    );

    // Drop the extra turn, zero hue and saturation for gray
    always_comb
    begin
        hue_wrap = (hue_quot >= QUOT_W'(HUE_TURN)) ? hue_quot - QUOT_W'(HUE_TURN) : hue_quot;
        hsl_next.hue           = gray_out ? 9'd0 : hue_wrap[8:0];
        hsl_next.saturation_q8 = gray_out ? 15'd0 : sat_quot[14:0];
        hsl_next.lightness_q8  = light_out;
    end

    assign done = done_reg;
    assign hsl  = hsl_reg;

endmodule

/* sv/rgbhsl_div.sv */
module rgbhsl_div #(
    parameter int DVS_W  = 8,
    parameter int QUOT_W = 15,
    parameter int SIDE_W = 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [DVS_W+QUOT_W-1:0] dividend,
    input  logic [DVS_W-1:0]        divisor,
    input  logic [SIDE_W-1:0]       in_side,
    output logic                    out_valid,
    output logic [QUOT_W-1:0]       quotient,
    output logic [SIDE_W-1:0]       out_side
);

    // Restoring divider, one quotient bit per stage. The quotient must fit
    // in QUOT_W bits, so the upper dividend bits start out below the divisor.
    logic              vld_reg  [QUOT_W];
    logic [QUOT_W-1:0] bits_reg [QUOT_W];
    logic [SIDE_W-1:0] side_reg [QUOT_W];
    logic [DVS_W-1:0]  rem_reg  [QUOT_W-1];
    logic [DVS_W-1:0]  dvs_reg  [QUOT_W-1];

    for (genvar i = 0; i < QUOT_W; i++) begin : g_stage
        logic              vld_in;
        logic [DVS_W-1:0]  rem_in;
        logic [DVS_W-1:0]  dvs_in;
        logic [QUOT_W-1:0] bits_in;
        logic [SIDE_W-1:0] side_in;
        logic [DVS_W:0]    trial;
        logic [DVS_W:0]    diff;
        logic              take;
        logic [DVS_W-1:0]  rem_next;
        logic [QUOT_W-1:0] bits_next;

        // Pick up the previous stage, or the request for the first one
        if (i == 0) begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = dividend[DVS_W+QUOT_W-1:QUOT_W];
            assign bits_in = dividend[QUOT_W-1:0];
            assign dvs_in  = divisor;
            assign side_in = in_side;
        end else begin : g_next
            assign vld_in  = vld_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign bits_in = bits_reg[i-1];
            assign dvs_in  = dvs_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        // Shift in the next dividend bit, subtract where it fits
        assign trial = {rem_in, bits_in[QUOT_W-1]};
        assign diff  = trial - {1'b0, dvs_in};
        assign take  = (trial >= {1'b0, dvs_in});

        always_comb
        begin
            rem_next  = take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            bits_next = {bits_in[QUOT_W-2:0], take};
        end

        // Advance the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else
            begin
                vld_reg[i] <= vld_in;
            end
        end

        // Advance quotient bits and side data
        always_ff @(posedge clk)
        begin
            bits_reg[i] <= bits_next;
            side_reg[i] <= side_in;
        end

        // Carry remainder and divisor to the stages that still need them
        if (i < QUOT_W - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[i] <= rem_next;
                dvs_reg[i] <= dvs_in;
            end
        end
    end

    assign out_valid = vld_reg[QUOT_W-1];
    assign quotient  = bits_reg[QUOT_W-1];
    assign out_side  = side_reg[QUOT_W-1];

endmodule

/* sv/rgbhsl_checker.sv */
module rgbhsl_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input rgbhsl_pkg::rgb_t pixel,
    input logic             done,
    input rgbhsl_pkg::hsl_t hsl
);

    import rgbhsl_pkg::*;

    // Every request yields a result
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("request without result at fixed latency");

    // No result without a request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching request");

    // Gray pixels carry no hue and no saturation
    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && pixel.red == pixel.green && pixel.green == pixel.blue)
        |-> ##LATENCY (hsl.hue == 9'd0 && hsl.saturation_q8 == 15'd0))
        else $error("gray pixel with hue or saturation");

    // Results stay in range; zero saturation means zero hue
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hsl.hue < HUE_TURN && hsl.saturation_q8 <= PCT_Q8 &&
                  hsl.lightness_q8 <= PCT_Q8 &&
                  (hsl.saturation_q8 != 15'd0 || hsl.hue == 9'd0)))
        else $error("result out of range");

endmodule

bind rgb_to_hsl_converter rgbhsl_checker u_checker (.*);
